// ----- sv/npcm_pkg.sv -----
package npcm_pkg;

   // Sizes of the palette store and of the raster.
   localparam int PALETTE_ENTRIES = 256;
   localparam int MAX_DIMENSION   = 1024;

   // Fixed field widths.
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 8;
   localparam int CODE_W  = 4;
   localparam int COORD_W = 12;
   localparam int CFG_W   = 11;
   localparam int DIST_W  = 10;
   localparam int NUM_HUES = 16;
   localparam int HUE_W   = 4;

   // Derived widths.
   localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int CNT_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_ORIGIN_X     = 2'd0,
      REG_ORIGIN_Y     = 2'd1,
      REG_IMAGE_WIDTH  = 2'd2,
      REG_IMAGE_HEIGHT = 2'd3
   } cfg_reg_type;

   // Input item kinds.
   localparam logic ACT_PALETTE = 1'b0;
   localparam logic ACT_PIXEL   = 1'b1;

   // Display color codes forced for strong hues.
   localparam logic [CODE_W-1:0] CODE_BLUE        = 4'd1;
   localparam logic [CODE_W-1:0] CODE_GREEN       = 4'd2;
   localparam logic [CODE_W-1:0] CODE_RED         = 4'd4;
   localparam logic [CODE_W-1:0] CODE_LIGHT_BLUE  = 4'd9;
   localparam logic [CODE_W-1:0] CODE_LIGHT_GREEN = 4'd10;
   localparam logic [CODE_W-1:0] CODE_LIGHT_RED   = 4'd12;
   localparam logic [CODE_W-1:0] CODE_NONE        = 4'd0;

   // Thresholds of the strong-hue test.
   localparam logic [CHAN_W-1:0] STRONG_HIGH = 8'd150;
   localparam logic [CHAN_W-1:0] STRONG_LOW  = 8'd100;
   localparam logic [CHAN_W-1:0] PURE_LOW    = 8'd50;

   // Display color table, one entry per code.
   localparam logic [CHAN_W-1:0] HUE_R [NUM_HUES] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd168,
      8'd84, 8'd127, 8'd127, 8'd127, 8'd255, 8'd255, 8'd255, 8'd255};
   localparam logic [CHAN_W-1:0] HUE_G [NUM_HUES] = '{
      8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd127, 8'd168,
      8'd84, 8'd127, 8'd255, 8'd255, 8'd127, 8'd127, 8'd255, 8'd255};
   localparam logic [CHAN_W-1:0] HUE_B [NUM_HUES] = '{
      8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd168,
      8'd84, 8'd255, 8'd127, 8'd255, 8'd127, 8'd255, 8'd127, 8'd255};

   // Write command from the color matcher into the palette store.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [CODE_W-1:0] code;
   } pal_wr_type;

endpackage

// ----- sv/npcm_req_if.sv -----
interface npcm_req_if;
   import npcm_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [PIX_W-1:0]  pixel_index;

   modport source (output valid, action, red, green, blue, pixel_index, input ready);
   modport sink (input valid, action, red, green, blue, pixel_index, output ready);
endinterface

// ----- sv/npcm_rsp_if.sv -----
interface npcm_rsp_if;
   import npcm_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] screen_x;
   logic [COORD_W-1:0] screen_y;
   logic [CODE_W-1:0]  display_color;
   logic               frame_last;

   modport source (output valid, screen_x, screen_y, display_color, frame_last,
                   input ready);
   modport sink (input valid, screen_x, screen_y, display_color, frame_last,
                 output ready);
endinterface

// ----- sv/npcm_csr_if.sv -----
interface npcm_csr_if;
   import npcm_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       index;
   logic [CFG_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/nearest_palette_color_mapper.sv -----
// Nearest palette color mapper. Palette beats (action 0) carry RGB entries
// that are written in order to a 256-entry code store; each entry is mapped
// to the nearest of 16 display colors by Manhattan distance, with strong red,
// green and blue forced to the pure or light shade. Palette beats give no
// result. The 16 distances are registered as the beat is taken, and the
// minimum tree and the store write follow in the next cycle. Pixel beats
// (action 1) read the store through its single registered read port and
// leave with screen coordinates through the lookup stage and the output
// register; rows arrive bottom-up and are flipped on screen. One beat of
// either kind is accepted every cycle while the result side keeps up; a pixel
// that reads an entry still being written sees the new code through a
// forwarding path. Writing image_width or image_height restarts the frame.
// Configure only while the block is idle.
module nearest_palette_color_mapper (
   input logic         clock,
   input logic         reset,
   npcm_req_if.sink    req_ch,
   npcm_rsp_if.source  rsp_ch,
   npcm_csr_if.sink    csr_ch
);
   import npcm_pkg::*;

   localparam logic [PIX_W:0] PIX_LIMIT = (PIX_W + 1)'(PALETTE_ENTRIES);

   logic               req_take;
   logic               pix_acc;
   logic               pal_acc;
   logic               csr_acc;
   pal_wr_type         pal_wr;
   logic [CODE_W-1:0]  rd_code;

   logic [CFG_W-1:0]   origin_x_ff, origin_y_ff;
   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic               col_end, row_end;

   logic               p1_valid_ff, p1_valid_in;
   logic [COORD_W-1:0] p1_x_ff, p1_y_ff;
   logic               p1_last_ff, p1_range_ff;
   logic               p1_move;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic               rsp_last_ff;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      int d;
      d = int'(v);
      if (d == 0) begin
         d = 1;
      end else if (d > MAX_DIMENSION) begin
         d = MAX_DIMENSION;
      end
      return DIM_W'(d);
   endfunction

   // Handshake.
   assign p1_move      = p1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !p1_valid_ff || p1_move;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign pix_acc      = req_take && (req_ch.action == ACT_PIXEL);
   assign pal_acc      = req_take && (req_ch.action == ACT_PALETTE);
   assign csr_ch.ready = 1'b1;
   assign csr_acc      = csr_ch.valid;

   // Palette mapping and code store.
   npcm_color_match u_match (
      .clock   (clock),
      .reset   (reset),
      .load_en (pal_acc),
      .red     (req_ch.red),
      .green   (req_ch.green),
      .blue    (req_ch.blue),
      .wr      (pal_wr)
   );

   npcm_palette_store u_store (
      .clock   (clock),
      .wr      (pal_wr),
      .rd_en   (pix_acc),
      .rd_addr (req_ch.pixel_index[IDX_W-1:0]),
      .rd_code (rd_code)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= DIM_W'(1);
         height_ff   <= DIM_W'(1);
      end else if (csr_acc) begin
         unique case (cfg_reg_type'(csr_ch.index))
            REG_ORIGIN_X:     origin_x_ff <= csr_ch.data;
            REG_ORIGIN_Y:     origin_y_ff <= csr_ch.data;
            REG_IMAGE_WIDTH:  width_ff    <= clamp_dim(csr_ch.data);
            REG_IMAGE_HEIGHT: height_ff   <= clamp_dim(csr_ch.data);
         endcase
      end
   end

   // Raster counters.
   assign col_end = (DIM_W'(col_ff) + DIM_W'(1)) == width_ff;
   assign row_end = (DIM_W'(row_ff) + DIM_W'(1)) == height_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_acc && (cfg_reg_type'(csr_ch.index) == REG_IMAGE_WIDTH ||
                      cfg_reg_type'(csr_ch.index) == REG_IMAGE_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end else if (pix_acc) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Lookup stage: coordinates travel beside the store read.
   assign p1_valid_in = pix_acc ? 1'b1 : (p1_move ? 1'b0 : p1_valid_ff);

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         p1_x_ff     <= COORD_W'(origin_x_ff) + COORD_W'(col_ff);
         p1_y_ff     <= COORD_W'(origin_y_ff) + COORD_W'(height_ff)
                        - COORD_W'(1) - COORD_W'(row_ff);
         p1_last_ff  <= col_end && row_end;
         p1_range_ff <= {1'b0, req_ch.pixel_index} < PIX_LIMIT;
      end
   end

   // Output register.
   assign rsp_valid_in = p1_move ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_move) begin
         rsp_x_ff    <= p1_x_ff;
         rsp_y_ff    <= p1_y_ff;
         rsp_code_ff <= p1_range_ff ? rd_code : CODE_NONE;
         rsp_last_ff <= p1_last_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.screen_x      = rsp_x_ff;
   assign rsp_ch.screen_y      = rsp_y_ff;
   assign rsp_ch.display_color = rsp_code_ff;
   assign rsp_ch.frame_last    = rsp_last_ff;

   // A pixel beat always lands in the lookup stage.
   a_pix_to_p1: assert property (@(posedge clock) disable iff (reset)
      pix_acc |=> p1_valid_ff)
      else $error("pixel beat lost before lookup stage");

   // A palette beat produces a store write in the next cycle.
   a_pal_write: assert property (@(posedge clock) disable iff (reset)
      pal_acc |=> pal_wr.en)
      else $error("palette beat did not reach the store");

   // The counters restart after the last pixel of a frame.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (pix_acc && col_end && row_end) |=> (col_ff == '0 && row_ff == '0))
      else $error("raster counters did not restart after frame end");

   // With both stages full and the result stalled, no beat is taken.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (p1_valid_ff && rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("beat accepted while pipeline full");

endmodule

// ----- sv/npcm_color_match.sv -----
module npcm_color_match (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_en,
   input  logic [npcm_pkg::CHAN_W-1:0] red,
   input  logic [npcm_pkg::CHAN_W-1:0] green,
   input  logic [npcm_pkg::CHAN_W-1:0] blue,
   output npcm_pkg::pal_wr_type    wr
);
   import npcm_pkg::*;

   logic [CHAN_W-1:0] HALF_UNUSED;
   logic [IDX_W-1:0]  load_ptr_ff, load_ptr_in;
   logic              s1_valid_ff;
   logic [IDX_W-1:0]  s1_addr_ff;
   logic [DIST_W-1:0] s1_dist_ff [NUM_HUES];
   logic              s1_strong_ff;
   logic [CODE_W-1:0] s1_strong_code_ff;
   logic [DIST_W-1:0] dist_in [NUM_HUES];
   logic              strong_in;
   logic [CODE_W-1:0] strong_code_in;
   logic [DIST_W-1:0] l1_d [8];
   logic [HUE_W-1:0]  l1_k [8];
   logic [DIST_W-1:0] l2_d [4];
   logic [HUE_W-1:0]  l2_k [4];
   logic [DIST_W-1:0] l3_d [2];
   logic [HUE_W-1:0]  l3_k [2];
   logic [HUE_W-1:0]  best_k;

   assign HALF_UNUSED = '0;

   function automatic logic [DIST_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return DIST_W'(d);
   endfunction

   // Stage one: Manhattan distance to every display color, and the strong-hue test.
   always_comb begin
      for (int k = 0; k < NUM_HUES; k++) begin
         dist_in[k] = abs_diff(red, HUE_R[k]) + abs_diff(green, HUE_G[k])
                    + abs_diff(blue, HUE_B[k]);
      end
      strong_in      = 1'b0;
      strong_code_in = CODE_NONE;
      priority if (red < STRONG_LOW && green < STRONG_LOW && blue > STRONG_HIGH) begin
         strong_in      = 1'b1;
         strong_code_in = (red < PURE_LOW && green < PURE_LOW) ? CODE_BLUE
                                                               : CODE_LIGHT_BLUE;
      end else if (red < STRONG_LOW && green > STRONG_HIGH && blue < STRONG_LOW) begin
         strong_in      = 1'b1;
         strong_code_in = (red < PURE_LOW && blue < PURE_LOW) ? CODE_GREEN
                                                              : CODE_LIGHT_GREEN;
      end else if (red > STRONG_HIGH && green < STRONG_LOW && blue < STRONG_LOW) begin
         strong_in      = 1'b1;
         strong_code_in = (green < PURE_LOW && blue < PURE_LOW) ? CODE_RED
                                                                : CODE_LIGHT_RED;
      end else begin
         strong_in      = 1'b0;
         strong_code_in = CODE_NONE | CODE_W'(HALF_UNUSED);
      end
   end

   // Load pointer wraps after the last palette entry.
   always_comb begin
      load_ptr_in = load_ptr_ff;
      if (load_en) begin
         load_ptr_in = (load_ptr_ff == IDX_W'(PALETTE_ENTRIES - 1)) ? '0
                                                                   : load_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         load_ptr_ff <= load_ptr_in;
         s1_valid_ff <= load_en;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         s1_addr_ff        <= load_ptr_ff;
         s1_dist_ff        <= dist_in;
         s1_strong_ff      <= strong_in;
         s1_strong_code_ff <= strong_code_in;
      end
   end

   // Stage two: minimum tree; on a tie the lower code keeps its place.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         if (s1_dist_ff[2*i+1] < s1_dist_ff[2*i]) begin
            l1_d[i] = s1_dist_ff[2*i+1];
            l1_k[i] = HUE_W'(2*i+1);
         end else begin
            l1_d[i] = s1_dist_ff[2*i];
            l1_k[i] = HUE_W'(2*i);
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (l1_d[2*i+1] < l1_d[2*i]) begin
            l2_d[i] = l1_d[2*i+1];
            l2_k[i] = l1_k[2*i+1];
         end else begin
            l2_d[i] = l1_d[2*i];
            l2_k[i] = l1_k[2*i];
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (l2_d[2*i+1] < l2_d[2*i]) begin
            l3_d[i] = l2_d[2*i+1];
            l3_k[i] = l2_k[2*i+1];
         end else begin
            l3_d[i] = l2_d[2*i];
            l3_k[i] = l2_k[2*i];
         end
      end
      best_k = (l3_d[1] < l3_d[0]) ? l3_k[1] : l3_k[0];
   end

   // The store write happens at the end of stage two.
   assign wr.en   = s1_valid_ff;
   assign wr.addr = s1_addr_ff;
   assign wr.code = s1_strong_ff ? s1_strong_code_ff : CODE_W'(best_k);

endmodule

// ----- sv/npcm_palette_store.sv -----
module npcm_palette_store (
   input  logic                       clock,
   input  npcm_pkg::pal_wr_type       wr,
   input  logic                       rd_en,
   input  logic [npcm_pkg::IDX_W-1:0] rd_addr,
   output logic [npcm_pkg::CODE_W-1:0] rd_code
);
   import npcm_pkg::*;

   logic [CODE_W-1:0] palette_mem [PALETTE_ENTRIES];
   logic [CODE_W-1:0] rd_data_ff;
   logic [CODE_W-1:0] fwd_code_ff;
   logic              fwd_hit_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         palette_mem[wr.addr] <= wr.code;
      end
      if (rd_en) begin
         rd_data_ff <= palette_mem[rd_addr];
      end
   end

   // A write to the same entry in the read cycle is forwarded past the array.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_hit_ff  <= wr.en && (wr.addr == rd_addr);
         fwd_code_ff <= wr.code;
      end
   end

   assign rd_code = fwd_hit_ff ? fwd_code_ff : rd_data_ff;

endmodule
